// ----- src/psuf_pkg.sv -----
// Package: shared sizes and the forest entry type for the percolation block.
`timescale 1ns / 1ps
package psuf_pkg;
    localparam int MAX_SIDE   = 64;
    localparam int SITE_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int NODE_COUNT = SITE_COUNT + 2;
    localparam int SITE_W     = $clog2(SITE_COUNT);
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int SIDE_W     = 7;
    localparam int RANK_W     = 4;
    localparam int RANK_MAX   = 15;
    localparam int LINK_W     = RANK_W + NODE_W;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [NODE_W-1:0] parent;
    } t_link;
endpackage

// ----- src/psuf_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module psuf_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/percolation_site_union_find.sv -----
// Top level: percolation grid with a union-find forest held in RAM.
//
//  channel | dir | handshake          | payload
//  s       | in  | i_s_tvalid/o_s_tready | tuser: func; tdata: site_row, site_col
//  m       | out | o_m_tvalid/i_m_tready | tdata: percolates, was_open, open_sites
//  cfg     | in  | i_cfg_we              | i_cfg_wdata: grid_side
//
// An open does a site lookup, one candidate step each (up to six plus the closing check),
// a neighbor probe per neighbor candidate, per union two root walks of a read and a check per node
// on the path plus 1-2 link writes, two more walks for the closing top/bottom compare, and
// the load of the result. Walks through the parent RAM set the time.
// Reset, a clear transaction and a grid_side write each start a clearing pass over the
// forest RAM and the site RAM; no transaction is accepted meanwhile.
// One transaction is worked at a time; a finished result waits in the output register
// while the next transaction is taken, and a stalled output only holds the finish step.
`timescale 1ns / 1ps
module percolation_site_union_find (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic                        i_s_tuser,   // [0] func
    input  logic [15:0]                 i_s_tdata,   // [5:0] site_row, [11:6] site_col
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [15:0]                 o_m_tdata,   // [0] percolates, [1] was_open,
                                                     // [14:2] open_sites
    input  logic                        i_cfg_we,
    input  logic [psuf_pkg::SIDE_W-1:0] i_cfg_wdata
);
    import psuf_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;
    localparam logic [3:0] S_SCHK = 4'd3;
    localparam logic [3:0] S_CAND = 4'd4;
    localparam logic [3:0] S_NCHK = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FCHK = 4'd7;
    localparam logic [3:0] S_LINK = 4'd8;
    localparam logic [3:0] S_RANK = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam logic [2:0] K_END = 3'd6;

    logic [3:0]        r_state;
    logic [NODE_W-1:0] r_cnt;
    logic              r_clr_resp;
    logic [SIDE_W-1:0] r_side;
    logic [5:0]        r_row, r_col;
    logic [SITE_W-1:0] r_idx;
    logic [NODE_W-1:0] r_bottom;
    logic              r_inrange;
    logic [2:0]        r_k;
    logic              r_report;
    logic              r_sel;
    logic [NODE_W-1:0] r_x, r_partner, r_ra, r_rb;
    logic [RANK_W-1:0] r_rka, r_rkb;
    logic [NODE_W-1:0] r_open;
    logic              r_was, r_perc;
    logic              r_ov, r_operc, r_owas;
    logic [NODE_W-1:0] r_ocnt;

    // RAM ports
    logic              site_we, site_wd, site_rd;
    logic [SITE_W-1:0] site_wa, site_ra;
    logic              link_we;
    logic [NODE_W-1:0] link_wa, link_ra;
    t_link             link_wd, link_rd;

    psuf_ram #(.W(1), .D(SITE_COUNT)) u_site (
        .i_clk(i_clk), .i_we(site_we), .i_waddr(site_wa), .i_wdata(site_wd),
        .i_raddr(site_ra), .o_rdata(site_rd)
    );
    psuf_ram #(.W(LINK_W), .D(NODE_COUNT)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(link_ra), .o_rdata(link_rd)
    );

    // Request decode
    logic [5:0]        in_row, in_col;
    logic [NODE_W-1:0] prod, sq;
    logic [SIDE_W-1:0] cfg_side;
    assign in_row = i_s_tdata[5:0];
    assign in_col = i_s_tdata[11:6];
    assign prod   = NODE_W'(in_row) * NODE_W'(r_side);
    assign sq     = NODE_W'(r_side) * NODE_W'(r_side);
    always_comb begin
        if (i_cfg_wdata < SIDE_W'(2)) begin
            cfg_side = SIDE_W'(2);
        end else if (i_cfg_wdata > SIDE_W'(MAX_SIDE)) begin
            cfg_side = SIDE_W'(MAX_SIDE);
        end else begin
            cfg_side = i_cfg_wdata;
        end
    end

    // Union candidate for the current step: partner node, neighbor site, gating
    logic              cand_ok, cand_probe;
    logic [SITE_W-1:0] cand_site;
    logic [NODE_W-1:0] cand_node, me;
    assign me = NODE_W'(r_idx) + NODE_W'(1);
    always_comb begin
        cand_ok    = 1'b0;
        cand_probe = 1'b0;
        cand_site  = r_idx;
        unique case (r_k)
            3'd0: cand_ok = (r_row == 6'd0);
            3'd1: cand_ok = ({1'b0, r_row} == r_side - SIDE_W'(1));
            3'd2: begin
                cand_ok   = ({1'b0, r_row} + SIDE_W'(1) < r_side);
                cand_site = r_idx + SITE_W'(r_side);
            end
            3'd3: begin
                cand_ok   = (r_row != 6'd0);
                cand_site = r_idx - SITE_W'(r_side);
            end
            3'd4: begin
                cand_ok   = ({1'b0, r_col} + SIDE_W'(1) < r_side);
                cand_site = r_idx + SITE_W'(1);
            end
            3'd5: begin
                cand_ok   = (r_col != 6'd0);
                cand_site = r_idx - SITE_W'(1);
            end
            default: cand_ok = 1'b0;
        endcase
        cand_probe = (r_k != 3'd0) && (r_k != 3'd1);
        unique case (r_k)
            3'd0:    cand_node = '0;
            3'd1:    cand_node = r_bottom;
            default: cand_node = NODE_W'(cand_site) + NODE_W'(1);
        endcase
    end

    // RAM access control
    always_comb begin
        site_we = 1'b0;
        site_wa = r_cnt[SITE_W-1:0];
        site_wd = 1'b0;
        site_ra = (r_state == S_SRD) ? r_idx : cand_site;
        link_we = 1'b0;
        link_wa = r_cnt;
        link_wd = '{rank: '0, parent: r_cnt};
        link_ra = r_x;
        unique case (r_state)
            S_CLR: begin
                site_we = ~r_cnt[NODE_W-1];
                link_we = 1'b1;
            end
            S_SCHK: begin
                site_we = ~site_rd;
                site_wa = r_idx;
                site_wd = 1'b1;
            end
            S_LINK: begin
                link_we = 1'b1;
                if (r_rka < r_rkb) begin
                    link_wa = r_ra;
                    link_wd = '{rank: r_rka, parent: r_rb};
                end else begin
                    link_wa = r_rb;
                    link_wd = '{rank: r_rkb, parent: r_ra};
                end
            end
            S_RANK: begin
                link_we = 1'b1;
                link_wa = r_ra;
                link_wd = '{rank: r_rka + RANK_W'(1), parent: r_ra};
            end
            default: ;
        endcase
    end

    // hold off the input while a register write restarts the trial
    assign o_s_tready = (r_state == S_IDLE) && !i_cfg_we;

    // load the output register from the finish step
    logic done_load;
    assign done_load = (r_state == S_DONE) && !i_cfg_we && (!r_ov || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_cnt      <= '0;
            r_clr_resp <= 1'b0;
            r_side     <= SIDE_W'(40);
            r_ov       <= 1'b0;
            r_open     <= '0;
        end else begin
            if (done_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                // restart the trial: node numbering follows grid_side
                r_side     <= cfg_side;
                r_state    <= S_CLR;
                r_cnt      <= '0;
                r_clr_resp <= 1'b0;
                r_open     <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_s_tvalid) begin
                            r_row     <= in_row;
                            r_col     <= in_col;
                            r_idx     <= SITE_W'(prod + NODE_W'(in_col));
                            r_bottom  <= sq + NODE_W'(1);
                            r_inrange <= ({1'b0, in_row} < r_side) && ({1'b0, in_col} < r_side);
                            r_was     <= 1'b0;
                            if (i_s_tuser) begin
                                r_state    <= S_CLR;
                                r_cnt      <= '0;
                                r_clr_resp <= 1'b1;
                                r_open     <= '0;
                            end else begin
                                r_state <= S_SRD;
                            end
                        end
                    end
                    S_CLR: begin
                        r_cnt <= r_cnt + NODE_W'(1);
                        if (r_cnt == NODE_W'(NODE_COUNT - 1)) begin
                            r_perc  <= 1'b0;
                            r_state <= r_clr_resp ? S_DONE : S_IDLE;
                        end
                    end
                    S_SRD: begin
                        if (r_inrange) begin
                            r_k     <= 3'd0;
                            r_state <= S_SCHK;
                        end else begin
                            r_k     <= K_END;
                            r_state <= S_CAND;
                        end
                    end
                    S_SCHK: begin
                        if (site_rd) begin
                            r_was <= 1'b1;
                            r_k   <= K_END;
                        end else begin
                            r_open <= r_open + NODE_W'(1);
                        end
                        r_state <= S_CAND;
                    end
                    S_CAND: begin
                        r_sel <= 1'b0;
                        if (r_k == K_END) begin
                            // closing check: top root against bottom root
                            r_report  <= 1'b1;
                            r_x       <= '0;
                            r_partner <= r_bottom;
                            r_state   <= S_FRD;
                        end else if (!cand_ok) begin
                            r_k <= r_k + 3'd1;
                        end else begin
                            r_report  <= 1'b0;
                            r_x       <= me;
                            r_partner <= cand_node;
                            r_state   <= cand_probe ? S_NCHK : S_FRD;
                        end
                    end
                    S_NCHK: begin
                        if (site_rd) begin
                            r_state <= S_FRD;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_CAND;
                        end
                    end
                    S_FRD: begin
                        r_state <= S_FCHK;
                    end
                    S_FCHK: begin
                        if (link_rd.parent != r_x) begin
                            r_x     <= link_rd.parent;
                            r_state <= S_FRD;
                        end else if (!r_sel) begin
                            r_ra    <= r_x;
                            r_rka   <= link_rd.rank;
                            r_sel   <= 1'b1;
                            r_x     <= r_partner;
                            r_state <= S_FRD;
                        end else begin
                            r_rb  <= r_x;
                            r_rkb <= link_rd.rank;
                            if (r_report) begin
                                r_perc  <= (r_ra == r_x);
                                r_state <= S_DONE;
                            end else if (r_ra == r_x) begin
                                r_k     <= r_k + 3'd1;
                                r_state <= S_CAND;
                            end else begin
                                r_state <= S_LINK;
                            end
                        end
                    end
                    S_LINK: begin
                        if (r_rka == r_rkb && r_rka != RANK_W'(RANK_MAX)) begin
                            r_state <= S_RANK;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_CAND;
                        end
                    end
                    S_RANK: begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_CAND;
                    end
                    S_DONE: begin
                        if (done_load) begin
                            r_operc <= r_perc;
                            r_owas  <= r_was;
                            r_ocnt  <= r_open;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {1'b0, r_ocnt, r_owas, r_operc};

    a_link_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> (r_ra != r_rb)) else $error("link of one root");
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCHK) |-> (r_x < NODE_W'(NODE_COUNT))) else $error("walk off forest");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAND) |-> (r_k <= K_END)) else $error("candidate step overrun");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_cfg_we) |=> !o_s_tready)
        else $error("second transaction taken while busy");
endmodule

// ----- sim/tb_percolation_site_union_find.sv -----
// Testbench: percolation grid with union-find, checked against a behavioral predictor.
`timescale 1ns / 1ps
module tb_percolation_site_union_find;
    import psuf_pkg::*;

    typedef enum logic {OP_OPEN = 1'b0, OP_CLEAR = 1'b1} t_op;
    typedef enum logic {ROW_ITEM, ROW_SIDE} t_row_kind;

    typedef struct {
        logic        percolates;
        logic        was_open;
        logic [12:0] open_sites;
    } t_status;

    typedef struct {
        t_row_kind kind;
        t_op       op;
        int        row;
        int        col;
        int        side_wr;
        bit        typed;      // expected status typed in below
        t_status   want;
    } t_vec;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic                i_s_tuser = 1'b0;
    logic [15:0]         i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [15:0]         o_m_tdata;
    logic                i_cfg_we = 1'b0;
    logic [SIDE_W-1:0]   i_cfg_wdata = '0;

    percolation_site_union_find DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // Grid and forest as the block should hold them.
    bit      grid_open [SITE_COUNT];
    int      forest_up [NODE_COUNT];
    int      forest_rank [NODE_COUNT];
    int      open_count;
    int      side_now;
    t_status status_q[$];
    int      mismatches = 0;
    int      idle_mode = 0;    // 0 none, 1 sender, 2 receiver, 3 both
    bit      long_hold = 1'b0;

    function automatic void wipe_trial();
        for (int i = 0; i < NODE_COUNT; i++) begin
            forest_up[i] = i;
            forest_rank[i] = 0;
        end
        for (int i = 0; i < SITE_COUNT; i++) grid_open[i] = 1'b0;
        open_count = 0;
    endfunction

    // Root walk with path halving.
    function automatic int root_of(int x);
        int hops;
        hops = 0;
        while (forest_up[x] != x && hops < NODE_COUNT) begin
            forest_up[x] = forest_up[forest_up[x]];
            x = forest_up[x];
            hops++;
        end
        return x;
    endfunction

    function automatic void join_sets(int a, int b);
        int ra, rb;
        ra = root_of(a);
        rb = root_of(b);
        if (ra == rb) return;
        if (forest_rank[ra] < forest_rank[rb]) begin
            forest_up[ra] = rb;
        end else if (forest_rank[ra] > forest_rank[rb]) begin
            forest_up[rb] = ra;
        end else begin
            forest_up[rb] = ra;
            if (forest_rank[ra] < RANK_MAX) forest_rank[ra]++;
        end
    endfunction

    function automatic t_status open_site(t_op op, int r, int c);
        t_status s;
        int n, bot, idx, me;
        n = side_now;
        bot = n * n + 1;
        s.was_open = 1'b0;
        if (op == OP_CLEAR) begin
            wipe_trial();
        end else if (r < n && c < n) begin
            idx = r * n + c;
            me = idx + 1;
            if (grid_open[idx]) begin
                s.was_open = 1'b1;
            end else begin
                grid_open[idx] = 1'b1;
                open_count++;
                if (r == 0) join_sets(0, me);
                if (r == n - 1) join_sets(me, bot);
                if (r + 1 < n && grid_open[idx + n]) join_sets(me, me + n);
                if (r > 0 && grid_open[idx - n]) join_sets(me, me - n);
                if (c + 1 < n && grid_open[idx + 1]) join_sets(me, me + 1);
                if (c > 0 && grid_open[idx - 1]) join_sets(me, me - 1);
            end
        end
        s.percolates = (root_of(0) == root_of(bot));
        s.open_sites = open_count[12:0];
        return s;
    endfunction

    // Offer one transaction; predict it at the edge where it is taken.
    task automatic offer(t_op op, int r, int c, bit typed, t_status want);
        t_status s;
        while ((idle_mode == 1 || idle_mode == 3) &&
               $urandom_range(99) < (idle_mode == 1 ? 72 : 23)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0, c[5:0], r[5:0]};
        do @(posedge i_clk); while (!o_s_tready);
        s = open_site(op, r, c);
        if (typed && s != want)
            $display("typed row disagrees with prediction: op %0d r %0d c %0d", op, r, c);
        status_q.push_back(typed ? want : s);
    endtask

    // Drain, let the block finish any clearing pass, then write the side register.
    task automatic write_side(int v);
        int sat;
        i_s_tvalid <= 1'b0;
        wait (status_q.size() == 0);
        repeat (4300) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[SIDE_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sat = v & 7'h7f;
        side_now = sat < 2 ? 2 : (sat > MAX_SIDE ? MAX_SIDE : sat);
        wipe_trial();
    endtask

    // Receiver: random stalls by mode, plus one long hold-off on request.
    int hold_cycles = 0;
    always @(posedge i_clk) begin
        if (long_hold && hold_cycles < 800) begin
            hold_cycles <= hold_cycles + 1;
            i_m_tready  <= 1'b0;
        end else if (idle_mode >= 2) begin
            i_m_tready <= $urandom_range(99) >= (idle_mode == 2 ? 72 : 23);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Check every result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_status w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with nothing expected: %h", o_m_tdata);
            end else begin
                w = status_q.pop_front();
                if (o_m_tdata[0] !== w.percolates || o_m_tdata[1] !== w.was_open ||
                    o_m_tdata[14:2] !== w.open_sites) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp perc %0d was %0d open %0d, got %0d %0d %0d",
                                 w.percolates, w.was_open, w.open_sites,
                                 o_m_tdata[0], o_m_tdata[1], o_m_tdata[14:2]);
                end
            end
        end
    end

    function automatic t_vec vec(t_row_kind k, t_op op, int r, int c, int sw,
                                 int typed, int p, int w, int cnt);
        t_vec v;
        v.kind = k; v.op = op; v.row = r; v.col = c; v.side_wr = sw;
        v.typed = (typed != 0);
        v.want.percolates = (p != 0);
        v.want.was_open = (w != 0);
        v.want.open_sites = 13'(cnt);
        return v;
    endfunction

    t_vec dir_tab[$];

    initial begin
        t_status none;
        int sides[8] = '{5, 2, 64, 8, 3, 12, 4, 6};
        int count, r, c, pick;
        none = '{1'b0, 1'b0, 13'd0};
        side_now = 40;
        wipe_trial();

        // Directed rows: defaults, repeats, out of grid, clear, saturated sides.
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 0, 0, 0, 1, 0, 0, 1));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 0, 0, 0, 1, 0, 1, 1));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 63, 63, 0, 1, 0, 0, 1));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 40, 3, 0, 1, 0, 0, 1));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 39, 39, 0, 1, 0, 0, 2));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 0, 39, 0, 0, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_CLEAR, 0, 0, 0, 1, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 20, 20, 0, 1, 0, 0, 1));
        dir_tab.push_back(vec(ROW_SIDE, OP_OPEN, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 2, 0, 0, 1, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 0, 1, 0, 1, 0, 0, 1));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 1, 1, 0, 1, 1, 0, 2));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 1, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 0, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(vec(ROW_SIDE, OP_OPEN, 0, 0, 127, 0, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 63, 63, 0, 1, 0, 0, 1));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 0, 63, 0, 1, 0, 0, 2));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 63, 0, 0, 1, 0, 0, 3));
        dir_tab.push_back(vec(ROW_ITEM, OP_OPEN, 62, 63, 0, 0, 0, 0, 0));
        dir_tab.push_back(vec(ROW_ITEM, OP_CLEAR, 63, 63, 0, 1, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_SIDE)
                write_side(dir_tab[i].side_wr);
            else
                offer(dir_tab[i].op, dir_tab[i].row, dir_tab[i].col,
                      dir_tab[i].typed, dir_tab[i].typed ? dir_tab[i].want : none);
        end

        // Random phases; mostly in-grid opens so trials reach percolation.
        foreach (sides[p]) begin
            write_side(sides[p]);
            idle_mode <= p % 4;
            long_hold <= (p == 4);
            count = (sides[p] == 64) ? 40 : 160;
            for (int k = 0; k < count; k++) begin
                if (k == count / 2) idle_mode <= (p + 1) % 4;
                pick = $urandom_range(99);
                r = $urandom_range(sides[p] - 1);
                c = $urandom_range(sides[p] - 1);
                if (pick < 3) begin
                    offer(OP_CLEAR, $urandom_range(63), $urandom_range(63), 0, none);
                end else if (pick < 10) begin
                    r = $urandom_range(63);
                    c = $urandom_range(63);
                    if (sides[p] < 64 && r < sides[p] && c < sides[p])
                        r = $urandom_range(63, sides[p]);
                    offer(OP_OPEN, r, c, 0, none);
                end else begin
                    offer(OP_OPEN, r, c, 0, none);
                end
            end
            long_hold <= 1'b0;
        end

        i_s_tvalid <= 1'b0;
        idle_mode  <= 0;
        wait (status_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
